### hdl/mormap_pkg.sv
// Shared types, widths and codes for the masked orthogonal rank mapper.
`default_nettype none

package mormap_pkg;

	localparam int DIM_SLOTS  = 5;
	localparam int SIZE_W     = 13;
	localparam int FIELD_W    = 16;
	localparam int WORLD_W    = 17;
	localparam int GS_W       = 18;
	localparam int RECIP_W    = 32;
	localparam int DIVD_W     = 33;
	localparam int CNT_W      = 6;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

	localparam logic [GS_W-1:0]    GS_CAP       = 18'h20000;
	localparam logic [WORLD_W-1:0] GS_FIELD_MAX = 17'h1FFFF;
	localparam logic [CNT_W-1:0]   DIV_STEPS    = 6'd33;
	localparam logic [DIVD_W-1:0]  RECIP_NUMER  = 33'h1_0000_0000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DIM_SIZE_0 = 3'd0,
		REG_DIM_SIZE_1 = 3'd1,
		REG_DIM_SIZE_2 = 3'd2,
		REG_DIM_SIZE_3 = 3'd3,
		REG_DIM_SIZE_4 = 3'd4,
		REG_DIM_MASK   = 3'd5,
		REG_WORLD_SIZE = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_INDIVISIBLE = 2'd1,
		STATUS_RANGE       = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SU_PROD,
		SU_RECIP_GO,
		SU_RECIP_WAIT,
		SU_COUNT_GO,
		SU_COUNT_WAIT,
		SU_READY
	} setup_state_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  size;
		logic               masked;
		logic [RECIP_W-1:0] recip;
	} cell_cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] qr;
		logic [FIELD_W-1:0] qg;
		status_t            status;
	} item_t;

	typedef struct packed {
		logic               busy;
		logic               fault;
		logic [GS_W-1:0]    gs;
		logic [WORLD_W-1:0] count;
	} setup_info_t;

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
		return (v == '0) ? SIZE_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

### hdl/masked_orthogonal_rank_mapper_unit.sv
// Top level of the masked orthogonal rank mapper: setup sequencer, cell chain, output register.
//
// channel   direction  payload (lowest bits first)
// s_axis    in         tdata: group_index[15:0], rank_in_group[31:16]
// m_axis    out        tdata: global_rank[15:0], group_size[32:16], group_count[49:33], zero pad
//                      tuser: status[1:0]
// cfg       in         cfg_we, cfg_addr (register index), cfg_wdata
//
// One item per cycle unless stalled or busy in setup; four stages per cell, one output register.
// After reset and after every configuration write the setup sequencer runs through its
// product, reciprocal and group-count steps, one divider bit per cycle;
// s_axis_tready stays low meanwhile.
// A stall on m_axis fills the cell stages back to front before s_axis_tready drops.
`default_nettype none

module masked_orthogonal_rank_mapper_unit import mormap_pkg::*; #(
	parameter int NUM_DIMS  = 5,
	parameter int RANK_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // group_index, rank_in_group
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // global_rank, group_size, group_count
	output logic [1:0]                 m_axis_tuser,   // status
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int ACC_W = RANK_BITS + 1;
	localparam int PAD_W = OUT_DATA_W - FIELD_W - 2 * WORLD_W;

	cell_cfg_t          cell_cfg [NUM_DIMS];
	logic [ACC_W-1:0]   stride [NUM_DIMS];
	setup_info_t        info;

	logic [NUM_DIMS:0]  chain_valid;
	logic [NUM_DIMS:0]  chain_ready;
	item_t              chain_item [NUM_DIMS+1];
	logic [ACC_W-1:0]   chain_acc [NUM_DIMS+1];

	logic [FIELD_W-1:0] group_index;
	logic [FIELD_W-1:0] rank_in_group;
	status_t            in_status;

	logic                 out_valid_q;
	logic [FIELD_W-1:0]   rank_q;
	logic [WORLD_W-1:0]   gsize_q;
	logic [WORLD_W-1:0]   count_q;
	status_t              status_q;
	logic [RANK_BITS-1:0] rank_sat;
	item_t                last_item;

	mormap_setup #(
		.NUM_DIMS  (NUM_DIMS),
		.RANK_BITS (RANK_BITS)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cell_cfg  (cell_cfg),
		.stride    (stride),
		.info      (info)
	);

	always_comb begin
		group_index   = s_axis_tdata[FIELD_W-1:0];
		rank_in_group = s_axis_tdata[2*FIELD_W-1:FIELD_W];
		priority if (info.fault) begin
			in_status = STATUS_INDIVISIBLE;
		end else if ((WORLD_W'(group_index) >= info.count) ||
				(GS_W'(rank_in_group) >= info.gs)) begin
			in_status = STATUS_RANGE;
		end else begin
			in_status = STATUS_OK;
		end
		chain_valid[0]       = s_axis_tvalid && !info.busy;
		chain_item[0].qr     = rank_in_group;
		chain_item[0].qg     = group_index;
		chain_item[0].status = in_status;
		chain_acc[0]         = '0;
		s_axis_tready        = chain_ready[0] && !info.busy;
	end

	for (genvar i = 0; i < NUM_DIMS; i++) begin : g_cell
		mormap_cell #(
			.RANK_BITS (RANK_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cell_cfg[i]),
			.stride    (stride[i]),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.in_acc    (chain_acc[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1]),
			.out_acc   (chain_acc[i+1])
		);
	end

	always_comb begin
		chain_ready[NUM_DIMS] = !out_valid_q || m_axis_tready;
		last_item             = chain_item[NUM_DIMS];
		rank_sat = chain_acc[NUM_DIMS][RANK_BITS] ? {RANK_BITS{1'b1}} :
			chain_acc[NUM_DIMS][RANK_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chain_ready[NUM_DIMS]) begin
			out_valid_q <= chain_valid[NUM_DIMS];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_ready[NUM_DIMS] && chain_valid[NUM_DIMS]) begin
			status_q <= last_item.status;
			gsize_q  <= (info.gs == GS_CAP) ? GS_FIELD_MAX : info.gs[WORLD_W-1:0];
			if (last_item.status == STATUS_OK) begin
				rank_q  <= FIELD_W'(rank_sat);
				count_q <= info.count;
			end else begin
				rank_q  <= '0;
				count_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, count_q, gsize_q, rank_q};
	assign m_axis_tuser  = status_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !info.busy)
		else $error("item accepted while setup sequencer busy");

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("input not blocked after configuration write");

	a_fault_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |->
		(m_axis_tdata[FIELD_W-1:0] == '0) && (count_q == '0))
		else $error("nonzero rank or count on faulted result");

	a_ok_has_groups: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == STATUS_OK)) |-> (count_q != '0))
		else $error("ok result with zero group count");

endmodule

`default_nettype wire

### hdl/mormap_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module mormap_div import mormap_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [GS_W-1:0]   divisor,
	output logic                   done,
	output logic [DIVD_W-1:0]      quot,
	output logic [GS_W-1:0]        rem
);

	logic [DIVD_W-1:0] dvd_q;
	logic [GS_W-1:0]   rem_q;
	logic [GS_W-1:0]   dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [GS_W:0]     trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIVD_W-1]};
		ge    = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIVD_W-2:0], ge};
			rem_q <= ge ? GS_W'(trial - {1'b0, dsr_q}) : trial[GS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### hdl/mormap_setup.sv
// Configuration registers and the sequencer that derives strides, reciprocals and group count.
`default_nettype none

module mormap_setup import mormap_pkg::*; #(
	parameter int NUM_DIMS  = 5,
	parameter int RANK_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cell_cfg_t                  cell_cfg [NUM_DIMS],
	output logic [RANK_BITS:0]         stride [NUM_DIMS],
	output setup_info_t                info
);

	localparam int IDX_W  = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int ACC_W  = RANK_BITS + 1;
	localparam int GP_W   = ACC_W + SIZE_W;
	localparam int GSP_W  = GS_W + SIZE_W;
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NUM_DIMS - 1);
	localparam logic [ACC_W-1:0] STRIDE_CAP = {1'b1, {RANK_BITS{1'b0}}};

	logic [SIZE_W-1:0]  dim_size_q [NUM_DIMS];
	logic [NUM_DIMS-1:0] mask_q;
	logic [WORLD_W-1:0] world_q;
	setup_state_t       state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [ACC_W-1:0]   g_q;
	logic [GS_W-1:0]    gs_q;
	logic [ACC_W-1:0]   stride_q [NUM_DIMS];
	logic [RECIP_W-1:0] recip_q [NUM_DIMS];
	logic [WORLD_W-1:0] count_q;
	logic               fault_q;

	logic [SIZE_W-1:0]  size_eff [NUM_DIMS];
	logic [SIZE_W-1:0]  cur_size;
	logic               cur_masked;
	logic [GP_W-1:0]    g_prod;
	logic [GSP_W-1:0]   gs_prod;
	logic [ACC_W-1:0]   g_next;
	logic [GS_W-1:0]    gs_next;
	logic               idx_last;

	logic               div_start;
	logic [DIVD_W-1:0]  div_dividend;
	logic [GS_W-1:0]    div_divisor;
	logic               div_done;
	logic [DIVD_W-1:0]  div_quot;
	logic [GS_W-1:0]    div_rem;
	logic               recip_we;
	logic               count_we;
	logic               idx_step;
	logic               busy;

	mormap_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			size_eff[i] = eff_size(dim_size_q[i]);
		end
		cur_size   = size_eff[idx_q];
		cur_masked = mask_q[idx_q];
		idx_last   = (idx_q == IDX_LAST);
		g_prod     = GP_W'(g_q) * GP_W'(cur_size);
		gs_prod    = GSP_W'(gs_q) * GSP_W'(cur_size);
		g_next     = (g_prod > GP_W'(STRIDE_CAP)) ? STRIDE_CAP : g_prod[ACC_W-1:0];
		gs_next    = (gs_prod > GSP_W'(GS_CAP)) ? GS_CAP : gs_prod[GS_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SU_PROD: begin
				if (idx_last) state_d = SU_RECIP_GO;
			end
			SU_RECIP_GO: begin
				state_d = SU_RECIP_WAIT;
			end
			SU_RECIP_WAIT: begin
				if (div_done) state_d = idx_last ? SU_COUNT_GO : SU_RECIP_GO;
			end
			SU_COUNT_GO: begin
				state_d = SU_COUNT_WAIT;
			end
			SU_COUNT_WAIT: begin
				if (div_done) state_d = SU_READY;
			end
			SU_READY: begin
				state_d = SU_READY;
			end
			default: begin
				state_d = SU_PROD;
			end
		endcase
		if (cfg_we) state_d = SU_PROD;
	end

	always_comb begin
		div_start    = (state_q == SU_RECIP_GO) || (state_q == SU_COUNT_GO);
		div_dividend = (state_q == SU_COUNT_GO) ? DIVD_W'(world_q) : RECIP_NUMER;
		div_divisor  = (state_q == SU_COUNT_GO) ? gs_q : GS_W'(cur_size);
		recip_we     = (state_q == SU_RECIP_WAIT) && div_done;
		count_we     = (state_q == SU_COUNT_WAIT) && div_done;
		idx_step     = (state_q == SU_PROD) || recip_we;
		busy         = (state_q != SU_READY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				dim_size_q[i] <= SIZE_W'(1);
			end
			mask_q  <= '0;
			world_q <= WORLD_W'(1);
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				if (cfg_addr == CFG_ADDR_W'(REG_DIM_SIZE_0) + CFG_ADDR_W'(i)) begin
					dim_size_q[i] <= cfg_wdata[SIZE_W-1:0];
				end
			end
			if (cfg_addr == REG_DIM_MASK) mask_q <= cfg_wdata[NUM_DIMS-1:0];
			if (cfg_addr == REG_WORLD_SIZE) world_q <= cfg_wdata[WORLD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_PROD;
			idx_q   <= '0;
			g_q     <= ACC_W'(1);
			gs_q    <= GS_W'(1);
			count_q <= '0;
			fault_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				idx_q <= '0;
				g_q   <= ACC_W'(1);
				gs_q  <= GS_W'(1);
			end else begin
				if (idx_step) idx_q <= idx_last ? '0 : idx_q + IDX_W'(1);
				if (state_q == SU_PROD) begin
					g_q <= g_next;
					if (cur_masked) gs_q <= gs_next;
				end
				if (count_we) begin
					count_q <= div_quot[WORLD_W-1:0];
					fault_q <= (div_rem != '0);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_we && state_q == SU_PROD) stride_q[idx_q] <= g_q;
		if (!cfg_we && recip_we) begin
			recip_q[idx_q] <= div_quot[DIVD_W-1] ? '1 : div_quot[RECIP_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIMS; i++) begin
			cell_cfg[i].size   = size_eff[i];
			cell_cfg[i].masked = mask_q[i];
			cell_cfg[i].recip  = recip_q[i];
			stride[i]          = stride_q[i];
		end
		info.busy  = busy;
		info.fault = fault_q;
		info.gs    = gs_q;
		info.count = count_q;
	end

endmodule

`default_nettype wire

### hdl/mormap_cell.sv
// One dimension cell: peels a mixed-radix digit and adds its weighted stride to the rank.
`default_nettype none

module mormap_cell import mormap_pkg::*; #(
	parameter int RANK_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_cfg_t        cfg,
	input  wire logic [RANK_BITS:0] stride,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire item_t            in_item,
	input  wire logic [RANK_BITS:0] in_acc,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output item_t                 out_item,
	output logic [RANK_BITS:0]    out_acc
);

	localparam int ACC_W = RANK_BITS + 1;
	localparam int MUL_W = FIELD_W + RECIP_W;
	localparam int PRD_W = SIZE_W + ACC_W;
	localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {RANK_BITS{1'b0}}};

	logic               v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	logic               en_s1, en_s2, en_s3, en_s4;
	item_t              item_s1, item_s2, item_s3, item_s4;
	logic [ACC_W-1:0]   acc_s1, acc_s2, acc_s3, acc_s4;
	logic [MUL_W-1:0]   prod_s1;
	logic [FIELD_W-1:0] qe_s2;
	logic [FIELD_W-1:0] t_s2;
	logic [SIZE_W-1:0]  digit_s3;

	logic [FIELD_W-1:0] q_in;
	logic [FIELD_W-1:0] qe;
	logic [FIELD_W-1:0] q_s2;
	logic [FIELD_W-1:0] r_s2;
	logic               fix_s2;
	logic [FIELD_W-1:0] quo_s2;
	logic [FIELD_W-1:0] rem_s2;
	item_t              item_nx;
	logic [PRD_W-1:0]   wprod;
	logic [PRD_W-1:0]   wsum;

	always_comb begin
		en_s4  = !v_s4_q || out_ready;
		en_s3  = !v_s3_q || en_s4;
		en_s2  = !v_s2_q || en_s3;
		en_s1  = !v_s1_q || en_s2;
		q_in   = cfg.masked ? in_item.qr : in_item.qg;
		qe     = prod_s1[MUL_W-1:RECIP_W];
		q_s2   = cfg.masked ? item_s2.qr : item_s2.qg;
		r_s2   = q_s2 - t_s2;
		fix_s2 = (r_s2 >= FIELD_W'(cfg.size));
		quo_s2 = fix_s2 ? qe_s2 + FIELD_W'(1) : qe_s2;
		rem_s2 = fix_s2 ? r_s2 - FIELD_W'(cfg.size) : r_s2;
		item_nx = item_s2;
		if (cfg.masked) item_nx.qr = quo_s2;
		else item_nx.qg = quo_s2;
		wprod  = PRD_W'(digit_s3) * PRD_W'(stride);
		wsum   = PRD_W'(acc_s3) + wprod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else begin
			if (en_s1) v_s1_q <= in_valid;
			if (en_s2) v_s2_q <= v_s1_q;
			if (en_s3) v_s3_q <= v_s2_q;
			if (en_s4) v_s4_q <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= MUL_W'(q_in) * MUL_W'(cfg.recip);
			item_s1 <= in_item;
			acc_s1  <= in_acc;
		end
		if (en_s2) begin
			qe_s2   <= qe;
			t_s2    <= FIELD_W'(qe * FIELD_W'(cfg.size));
			item_s2 <= item_s1;
			acc_s2  <= acc_s1;
		end
		if (en_s3) begin
			digit_s3 <= rem_s2[SIZE_W-1:0];
			item_s3  <= item_nx;
			acc_s3   <= acc_s2;
		end
		if (en_s4) begin
			item_s4 <= item_s3;
			acc_s4  <= (wsum > PRD_W'(ACC_CAP)) ? ACC_CAP : wsum[ACC_W-1:0];
		end
	end

	assign in_ready  = en_s1;
	assign out_valid = v_s4_q;
	assign out_item  = item_s4;
	assign out_acc   = acc_s4;

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for the masked orthogonal rank mapper: directed and random queries checked by a predictor.
`default_nettype none

module tb_top;
	import mormap_pkg::*;

	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 150;
	localparam logic [63:0] PROD_CAP = 64'd1 << 40;

	typedef logic [DIM_SLOTS-1:0][CFG_DATA_W-1:0] size_words_t;
	typedef logic [DIM_SLOTS-1:0][SIZE_W-1:0]     size_vec_t;

	typedef struct packed {
		logic [FIELD_W-1:0] global_rank;
		logic [WORLD_W-1:0] group_size;
		logic [WORLD_W-1:0] group_count;
		status_t            status;
	} mapped_rank_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // group_index, rank_in_group
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // global_rank, group_size, group_count
	logic [1:0]            m_axis_tuser;        // status
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_addr = REG_DIM_SIZE_0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	size_vec_t          cur_size = {DIM_SLOTS{SIZE_W'(1)}};
	logic [4:0]         cur_mask = '0;
	logic [WORLD_W-1:0] cur_world = WORLD_W'(1);

	mapped_rank_t pending_ranks[$];
	int           idle_pct = 30;
	int           mismatch_count = 0;
	int           hold_request = 0;
	int           hold_served = 0;
	int           hold_left = 0;

	masked_orthogonal_rank_mapper_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		if (a >= PROD_CAP)
			return PROD_CAP;
		p = a * b;
		return (p > PROD_CAP) ? PROD_CAP : p;
	endfunction

	function automatic logic [63:0] eff_dim(input logic [SIZE_W-1:0] v);
		return (v == '0) ? 64'd1 : 64'(v);
	endfunction

	function automatic logic [63:0] group_size_of(input size_vec_t sizes, input logic [4:0] mask);
		logic [63:0] gs;
		gs = 64'd1;
		for (int i = 0; i < DIM_SLOTS; i++)
			if (mask[i])
				gs = sat_mul(gs, eff_dim(sizes[i]));
		return gs;
	endfunction

	function automatic mapped_rank_t map_query(input logic [FIELD_W-1:0] gi,
			input logic [FIELD_W-1:0] ri);
		logic [63:0]  stride [DIM_SLOTS];
		logic [63:0]  span, gs, cnt, rank, ms, us, dsz, digit;
		mapped_rank_t res;
		span = 64'd1;
		rank = '0;
		cnt  = '0;
		gs   = group_size_of(cur_size, cur_mask);
		for (int i = 0; i < DIM_SLOTS; i++) begin
			stride[i] = span;
			span = sat_mul(span, eff_dim(cur_size[i]));
		end
		res.status = STATUS_OK;
		if (64'(cur_world) % gs != 0) begin
			res.status = STATUS_INDIVISIBLE;
		end else begin
			cnt = 64'(cur_world) / gs;
			if (64'(gi) >= cnt || 64'(ri) >= gs)
				res.status = STATUS_RANGE;
		end
		if (res.status == STATUS_OK) begin
			ms = 64'd1;
			us = 64'd1;
			for (int i = 0; i < DIM_SLOTS; i++) begin
				dsz = eff_dim(cur_size[i]);
				if (cur_mask[i]) begin
					digit = (64'(ri) / ms) % dsz;
					ms = sat_mul(ms, dsz);
				end else begin
					digit = (64'(gi) / us) % dsz;
					us = sat_mul(us, dsz);
				end
				rank += digit * stride[i];
			end
			if (rank > 64'hFFFF)
				rank = 64'hFFFF;
		end else begin
			cnt = '0;
		end
		res.global_rank = rank[FIELD_W-1:0];
		res.group_size  = (gs > 64'(GS_FIELD_MAX)) ? GS_FIELD_MAX : gs[WORLD_W-1:0];
		res.group_count = cnt[WORLD_W-1:0];
		return res;
	endfunction

	always @(posedge clk) begin : result_monitor
		mapped_rank_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_ranks.size() == 0) begin
				$display("%0t: result with nothing expected, tdata %h tuser %h",
					$time, m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want = pending_ranks.pop_front();
				if (m_axis_tdata[15:0] !== want.global_rank) begin
					$display("%0t: global_rank expected %0d actual %0d",
						$time, want.global_rank, m_axis_tdata[15:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[32:16] !== want.group_size) begin
					$display("%0t: group_size expected %0d actual %0d",
						$time, want.group_size, m_axis_tdata[32:16]);
					mismatch_count++;
				end
				if (m_axis_tdata[49:33] !== want.group_count) begin
					$display("%0t: group_count expected %0d actual %0d",
						$time, want.group_count, m_axis_tdata[49:33]);
					mismatch_count++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_axis_tuser);
					mismatch_count++;
				end
			end
		end
		if (hold_served != hold_request) begin
			hold_served = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	task automatic write_config(input size_words_t sizes, input logic [CFG_DATA_W-1:0] mask,
			input logic [CFG_DATA_W-1:0] world);
		for (int i = 0; i < DIM_SLOTS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= cfg_reg_t'(REG_DIM_SIZE_0 + i);
			cfg_wdata <= sizes[i];
			@(posedge clk);
			cur_size[i] = sizes[i][SIZE_W-1:0];
		end
		cfg_addr <= REG_DIM_MASK;
		cfg_wdata <= mask;
		@(posedge clk);
		cur_mask = mask[4:0];
		cfg_addr <= REG_WORLD_SIZE;
		cfg_wdata <= world;
		@(posedge clk);
		cur_world = world[WORLD_W-1:0];
		cfg_we <= 1'b0;
	endtask

	task automatic send_query(input logic [FIELD_W-1:0] gi, input logic [FIELD_W-1:0] ri);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {ri, gi};
		do @(posedge clk); while (!s_axis_tready);
		pending_ranks.insert(pending_ranks.size(), map_query(gi, ri));
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_ranks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly in-range queries for the current shape, the rest raw noise
	task automatic send_query_batch(input int n_items);
		logic [63:0]        gs, cnt;
		logic [FIELD_W-1:0] gi, ri;
		gs  = group_size_of(cur_size, cur_mask);
		cnt = 64'(cur_world) / gs;
		for (int n = 0; n < n_items; n++) begin
			if (cnt > 0 && $urandom_range(0, 99) < 80) begin
				gi = FIELD_W'($urandom_range(0, 32'((cnt > 65536) ? 65535 : cnt - 1)));
				ri = FIELD_W'($urandom_range(0, 32'((gs > 65536) ? 65535 : gs - 1)));
			end else begin
				gi = FIELD_W'($urandom);
				ri = FIELD_W'($urandom);
			end
			send_query(gi, ri);
		end
	endtask

	task automatic test_reset_defaults();
		send_query(16'd0, 16'd0);
		send_query(16'd1, 16'd0);
		send_query(16'hFFFF, 16'hFFFF);
		wait_drain();
	endtask

	task automatic test_mapping_and_wrap();
		// dims 0..4 = 3, 0 (treated as 1), 4, 2, 5; group is dims 1 and 3
		write_config({17'd5, 17'd2, 17'd4, 17'd0, 17'd3}, 17'b01010, 17'd240);
		send_query(16'd0, 16'd0);
		send_query(16'd119, 16'd1);
		send_query(16'd100, 16'd0);
		send_query(16'd120, 16'd0);
		send_query(16'd0, 16'd2);
		send_query(16'hFFFF, 16'hFFFF);
		wait_drain();
	endtask

	task automatic test_saturation();
		write_config({DIM_SLOTS{17'd8191}}, 17'b11111, 17'd65536);
		send_query(16'd0, 16'd0);
		send_query(16'hFFFF, 16'd0);
		wait_drain();
		// strides large enough to push the rank past its width
		write_config({17'd1, 17'd1, 17'd2, 17'd256, 17'd256}, 17'b00100, 17'd131070);
		send_query(16'd65534, 16'd1);
		send_query(16'd65534, 16'd0);
		send_query(16'd1, 16'd1);
		wait_drain();
	endtask

	task automatic test_zero_world_and_indivisible();
		write_config({DIM_SLOTS{17'd1}}, 17'b00000, 17'd0);
		send_query(16'd0, 16'd0);
		wait_drain();
		write_config({17'd1, 17'd1, 17'd1, 17'd1, 17'd3}, 17'b00001, 17'd10);
		send_query(16'd0, 16'd0);
		send_query(16'd5, 16'd7);
		wait_drain();
	endtask

	task automatic test_random_configs(input int n_phases, input int n_items);
		size_words_t           sizes;
		size_vec_t             raw;
		logic [4:0]            mask;
		logic [63:0]           gs, kmax;
		logic [CFG_DATA_W-1:0] world;
		int                    pick;
		for (int p = 0; p < n_phases; p++) begin
			for (int i = 0; i < DIM_SLOTS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					sizes[i] = CFG_DATA_W'($urandom_range(1, 4));
				else if (pick < 80)
					sizes[i] = CFG_DATA_W'($urandom_range(1, 16));
				else if (pick < 88)
					sizes[i] = '0;
				else if (pick < 95)
					sizes[i] = CFG_DATA_W'($urandom_range(1, 8191));
				else
					sizes[i] = CFG_DATA_W'($urandom_range(0, 131071));
				raw[i] = sizes[i][SIZE_W-1:0];
			end
			mask = 5'($urandom_range(0, 31));
			gs = group_size_of(raw, mask);
			if (gs > 65536 || $urandom_range(0, 99) < 15) begin
				world = CFG_DATA_W'($urandom_range(0, 131071));
			end else begin
				kmax = 65536 / gs;
				if ($urandom_range(0, 1) == 0 && kmax > 8)
					kmax = 8;
				world = CFG_DATA_W'(gs * $urandom_range(1, 32'(kmax)));
			end
			write_config(sizes, {12'($urandom), mask}, world);
			send_query_batch(n_items);
			wait_drain();
		end
	endtask

	task automatic test_no_idle_stretch();
		idle_pct = 0;
		test_random_configs(1, 120);
		idle_pct = 30;
	endtask

	task automatic test_backpressure();
		write_config({17'd2, 17'd3, 17'd2, 17'd4, 17'd3}, 17'b00101, 17'd144);
		idle_pct = 0;
		hold_request++;
		send_query_batch(80);
		wait_drain();
		idle_pct = 30;
	endtask

	task automatic test_drain_pause();
		send_query_batch(20);
		wait_drain();
		send_query_batch(20);
		wait_drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_mapping_and_wrap();
		test_saturation();
		test_zero_world_and_indivisible();
		test_random_configs(7, 100);
		test_no_idle_stretch();
		test_backpressure();
		test_random_configs(7, 100);
		test_drain_pause();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hdl/mormap_pkg.sv
hdl/mormap_div.sv
hdl/mormap_setup.sv
hdl/mormap_cell.sv
hdl/masked_orthogonal_rank_mapper_unit.sv
verif/tb_top.sv
